FILE: rtl/dgk_pkg.sv
// Shared types, constants and constant functions of the diagonal Gaussian kernel evaluator.
// No dependencies; every other file of the block but dgk_ram imports this package.
package dgk_pkg;

    // Default number of dimensions.
    localparam int MAX_DIM_DEF = 16;

    // Widths of the internal values.
    localparam int LEN_W  = 6;
    localparam int SUM_W  = 48;
    localparam int TERM_W = 40;
    localparam int K_W    = 16;
    localparam int VAL_W  = 48;
    localparam int SERIES_N = 20;

    // Configuration register indexes.
    localparam logic [1:0] CFG_VECTOR_LENGTH   = 2'd0;
    localparam logic [1:0] CFG_DERIVATIVE_MODE = 2'd1;

    // Input selector and result kind codes.
    localparam logic FUNC_WEIGHT = 1'b0;
    localparam logic FUNC_PAIR   = 1'b1;
    localparam logic KIND_DERIV  = 1'b0;
    localparam logic KIND_KERNEL = 1'b1;

    // Sums of 12.0 and more give a kernel value of zero.
    localparam logic [SUM_W-1:0] SUM_LIMIT = 48'h0000_000C_0000;

    // One finished vector handed from the front to the back.
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [LEN_W-1:0] len;
        logic             deriv;
        logic             bank;
    } t_job;

    // Queue status seen by the top level.
    typedef struct packed {
        logic       empty;
        logic       full;
        logic [1:0] count;
    } t_q_status;

    // e^-1 in Q0.31 from the 20-term Taylor series, each term truncated
    // (terms 2^31, 2^31, 2^30, 357913941, 89478485, ... alternating in sign).
    localparam longint unsigned E1_Q31 = 64'd790015085;

    // floor(2^32 / m) for the series divisors 1 to 20 (m = 1 uses 2^32 - 1).
    function automatic logic [31:0] f_recip(logic [4:0] m);
        logic [31:0] r;
        case (m)
            5'd1:    r = 32'd4294967295;
            5'd2:    r = 32'd2147483648;
            5'd3:    r = 32'd1431655765;
            5'd4:    r = 32'd1073741824;
            5'd5:    r = 32'd858993459;
            5'd6:    r = 32'd715827882;
            5'd7:    r = 32'd613566756;
            5'd8:    r = 32'd536870912;
            5'd9:    r = 32'd477218588;
            5'd10:   r = 32'd429496729;
            5'd11:   r = 32'd390451572;
            5'd12:   r = 32'd357913941;
            5'd13:   r = 32'd330382099;
            5'd14:   r = 32'd306783378;
            5'd15:   r = 32'd286331153;
            5'd16:   r = 32'd268435456;
            5'd17:   r = 32'd252645135;
            5'd18:   r = 32'd238609294;
            5'd19:   r = 32'd226050910;
            5'd20:   r = 32'd214748364;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/dgk_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port (read-first).
// No dependencies.
module dgk_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read; a read at the write address returns the old data.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/dgk_queue.sv
// Two-entry job queue between the front and the back of the kernel evaluator.
// Depends on dgk_pkg for the job and status types.
module dgk_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  dgk_pkg::t_job     i_job,
    input  logic              i_pop,
    output dgk_pkg::t_job     o_job,
    output dgk_pkg::t_q_status o_status
);
    import dgk_pkg::*;

    t_job       r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_count;

    // Storage is payload and needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    assign o_job           = r_mem[r_rd];
    assign o_status.empty  = (r_count == 2'd0);
    assign o_status.full   = (r_count == 2'd2);
    assign o_status.count  = r_count;

endmodule

FILE: rtl/dgk_front.sv
// Front of the kernel evaluator: accepts transactions, keeps the weight table and
// accumulates the weighted distance of a vector. Depends on dgk_pkg and dgk_ram.
module dgk_front #(
    parameter int MAX_DIM = dgk_pkg::MAX_DIM_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_func,
    input  logic [3:0]                          i_weight_index,
    input  logic [15:0]                         i_weight_value,
    input  logic signed [15:0]                  i_first_sample,
    input  logic signed [15:0]                  i_second_sample,
    input  logic [dgk_pkg::LEN_W-1:0]           i_len,
    input  logic                                i_deriv,
    input  logic                                i_bank_free,
    output logic                                o_push,
    output dgk_pkg::t_job                       o_job,
    output logic                                o_pt_we,
    output logic [((MAX_DIM > 1) ? $clog2(MAX_DIM) : 1):0] o_pt_addr,
    output logic signed [dgk_pkg::TERM_W-1:0]   o_pt_data
);
    import dgk_pkg::*;

    localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

    logic                 accept, pair_acc, wt_acc, is_last;
    logic [LEN_W-1:0]     r_count, cnt_inc;
    logic [31:0]          widx_ext;
    logic [15:0]          w_q;
    logic                 r_last_busy;
    logic                 r_bank;
    logic [SUM_W-1:0]     r_sum, sum_sat;
    logic [SUM_W:0]       sum_add;

    logic                 r1_valid, r2_valid, r3_valid;
    logic                 r1_last, r2_last, r3_last;
    logic [IW-1:0]        r1_idx, r2_idx, r3_idx;
    logic signed [16:0]   r1_d, r2_d;
    logic signed [33:0]   r2_wd;
    logic signed [21:0]   b;
    logic signed [43:0]   bb;
    logic signed [38:0]   db;
    logic [43:0]          r3_bb;
    logic signed [TERM_W-1:0] r3_term;

    // Handshake and classification of the transaction.
    assign o_ready  = !r_last_busy && i_bank_free;
    assign accept   = i_valid && o_ready;
    assign widx_ext = 32'(i_weight_index);
    assign pair_acc = accept && (i_func == FUNC_PAIR);
    assign wt_acc   = accept && (i_func == FUNC_WEIGHT) && (widx_ext < 32'(MAX_DIM));
    assign cnt_inc  = r_count + LEN_W'(1);
    assign is_last  = (cnt_inc >= i_len);

    dgk_ram #(
        .WIDTH (16),
        .DEPTH (2 ** IW)
    ) u_weights (
        .i_clk   (i_clk),
        .i_we    (wt_acc),
        .i_waddr (widx_ext[IW-1:0]),
        .i_wdata (i_weight_value),
        .i_re    (pair_acc),
        .i_raddr (r_count[IW-1:0]),
        .o_rdata (w_q)
    );

    // Control: element counter, pending last element, bank of the current vector.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_last_busy <= 1'b0;
            r_bank      <= 1'b0;
            r_sum       <= '0;
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r3_valid    <= 1'b0;
        end else begin
            r1_valid <= pair_acc;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            if (pair_acc) begin
                r_count <= is_last ? '0 : cnt_inc;
                if (is_last) begin
                    r_last_busy <= 1'b1;
                end
            end
            if (r3_valid) begin
                if (r3_last) begin
                    r_sum       <= '0;
                    r_bank      <= ~r_bank;
                    r_last_busy <= 1'b0;
                end else begin
                    r_sum <= sum_sat;
                end
            end
        end
    end

    // Arithmetic of the pipeline: difference, weighting, square and derivative term.
    assign b  = r2_wd[33:12];
    assign bb = b * b;
    assign db = r2_d * b;

    always_ff @(posedge i_clk) begin
        r1_d    <= 17'(i_first_sample) - 17'(i_second_sample);
        r1_idx  <= r_count[IW-1:0];
        r1_last <= is_last;
        r2_wd   <= $signed({1'b0, w_q}) * r1_d;
        r2_d    <= r1_d;
        r2_idx  <= r1_idx;
        r2_last <= r1_last;
        r3_bb   <= $unsigned(bb);
        r3_term <= -(TERM_W'(db) <<< 1);
        r3_idx  <= r2_idx;
        r3_last <= r2_last;
    end

    // Saturating accumulation of the squared weighted differences.
    assign sum_add = {1'b0, r_sum} + (SUM_W + 1)'(r3_bb);
    assign sum_sat = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];

    assign o_pt_we   = r3_valid;
    assign o_pt_addr = {r_bank, r3_idx};
    assign o_pt_data = r3_term;
    assign o_push    = r3_valid && r3_last;
    assign o_job.sum   = sum_sat;
    assign o_job.len   = i_len;
    assign o_job.deriv = i_deriv;
    assign o_job.bank  = r_bank;

endmodule

FILE: rtl/dgk_back.sv
// Back of the kernel evaluator: evaluates exp(-sum) with a shared multiply and divide
// sequence and emits derivative terms and the kernel value. Depends on dgk_pkg.
module dgk_back #(
    parameter int MAX_DIM = dgk_pkg::MAX_DIM_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_q_empty,
    input  dgk_pkg::t_job                       i_job,
    output logic                                o_pop,
    output logic                                o_busy,
    output logic                                o_pt_re,
    output logic [((MAX_DIM > 1) ? $clog2(MAX_DIM) : 1):0] o_pt_addr,
    input  logic signed [dgk_pkg::TERM_W-1:0]   i_pt_data,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic                                o_kind,
    output logic [3:0]                          o_elem,
    output logic [dgk_pkg::VAL_W-1:0]           o_value,
    output logic                                o_last
);
    import dgk_pkg::*;

    localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL_T = 4'd1;
    localparam logic [3:0] S_MUL_R = 4'd2;
    localparam logic [3:0] S_CORR0 = 4'd3;
    localparam logic [3:0] S_CORR1 = 4'd4;
    localparam logic [3:0] S_FIN   = 4'd5;
    localparam logic [3:0] S_SCALE = 4'd6;
    localparam logic [3:0] S_ROUND = 4'd7;
    localparam logic [3:0] S_RD    = 4'd8;
    localparam logic [3:0] S_DM1   = 4'd9;
    localparam logic [3:0] S_DM2   = 4'd10;
    localparam logic [3:0] S_DOUT  = 4'd11;
    localparam logic [3:0] S_KOUT  = 4'd12;

    localparam logic [31:0] E1 = E1_Q31[31:0];

    logic [3:0]        r_state;
    t_job              r_job;
    logic [31:0]       r_term, r_x, r_q, r_rem;
    logic [15:0]       r_t;
    logic [33:0]       r_pos, r_neg;
    logic [4:0]        r_kidx, m;
    logic [47:0]       r_p;
    logic [63:0]       r_prod;
    logic [3:0]        r_n;
    logic [32:0]       r_v;
    logic [K_W-1:0]    r_k;
    logic [LEN_W-1:0]  r_i;
    logic [35:0]       r_lo;
    logic signed [36:0] r_hi;
    logic [VAL_W-1:0]  r_dval;

    logic [31:0]       q1, rem1, q2;
    logic [64:0]       scale_p;
    logic [65:0]       scale_r;
    logic [33:0]       round_s;
    logic [18:0]       round_q;
    logic signed [57:0] dsum;
    logic              out_free, out_load;
    logic              load_kind;
    logic [3:0]        load_elem;
    logic [VAL_W-1:0]  load_val;

    assign m        = r_kidx + 5'd1;
    assign out_free = !o_valid || i_ready;

    // Quotient correction after the reciprocal multiply.
    assign q1   = (r_rem >= 32'(m)) ? r_q + 32'd1 : r_q;
    assign rem1 = (r_rem >= 32'(m)) ? r_rem - 32'(m) : r_rem;
    assign q2   = (rem1 >= 32'(m)) ? q1 + 32'd1 : q1;

    // Scaling by e^-1 and final rounding to Q0.16.
    assign scale_p = r_v * E1;
    assign scale_r = 66'(scale_p) + 66'(64'd1 << 30);
    assign round_s = 34'(r_v) + 34'd16384;
    assign round_q = round_s[33:15];

    // Derivative term times kernel value, rounded to Q16.16.
    assign dsum = (58'(r_hi) <<< 20) + 58'(r_lo) + 58'sd32768;

    // Output register load.
    always_comb begin
        out_load  = 1'b0;
        load_kind = KIND_KERNEL;
        load_elem = 4'd0;
        load_val  = VAL_W'(r_k);
        if (r_state == S_DOUT && out_free) begin
            out_load  = 1'b1;
            load_kind = KIND_DERIV;
            load_elem = r_i[3:0];
            load_val  = r_dval;
        end else if (r_state == S_KOUT && out_free) begin
            out_load = 1'b1;
        end
    end

    assign o_pop     = (r_state == S_IDLE) && !i_q_empty;
    assign o_busy    = (r_state != S_IDLE);
    assign o_pt_re   = (r_state == S_RD);
    assign o_pt_addr = {r_job.bank, r_i[IW-1:0]};

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_state <= (i_job.sum >= SUM_LIMIT) ?
                                   (i_job.deriv ? S_RD : S_KOUT) : S_MUL_T;
                    end
                end
                S_MUL_T: r_state <= (r_kidx == 5'(SERIES_N - 1)) ? S_FIN : S_MUL_R;
                S_MUL_R: r_state <= S_CORR0;
                S_CORR0: r_state <= S_CORR1;
                S_CORR1: r_state <= S_MUL_T;
                S_FIN:   r_state <= (r_n == 4'd0) ? S_ROUND : S_SCALE;
                S_SCALE: r_state <= (r_n == 4'd1) ? S_ROUND : S_SCALE;
                S_ROUND: r_state <= r_job.deriv ? S_RD : S_KOUT;
                S_RD:    r_state <= S_DM1;
                S_DM1:   r_state <= S_DM2;
                S_DM2:   r_state <= S_DOUT;
                S_DOUT: begin
                    if (out_free) begin
                        r_state <= (r_i + LEN_W'(1) == r_job.len) ? S_KOUT : S_RD;
                    end
                end
                S_KOUT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath registers of the sequence.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_job  <= i_job;
                r_term <= 32'h8000_0000;
                r_pos  <= '0;
                r_neg  <= '0;
                r_kidx <= '0;
                r_t    <= i_job.sum[15:0];
                r_n    <= i_job.sum[19:16];
                r_k    <= '0;
                r_i    <= '0;
            end
            S_MUL_T: begin
                if (r_kidx[0]) begin
                    r_neg <= r_neg + 34'(r_term);
                end else begin
                    r_pos <= r_pos + 34'(r_term);
                end
                r_p <= r_term * r_t;
            end
            S_MUL_R: begin
                r_x    <= r_p[47:16];
                r_prod <= r_p[47:16] * f_recip(m);
            end
            S_CORR0: begin
                r_q   <= r_prod[63:32];
                r_rem <= r_x - r_prod[63:32] * m;
            end
            S_CORR1: begin
                r_term <= q2;
                r_kidx <= r_kidx + 5'd1;
            end
            S_FIN: begin
                r_v <= (r_pos > r_neg) ? 33'(r_pos - r_neg) : '0;
            end
            S_SCALE: begin
                r_v <= scale_r[63:31];
                r_n <= r_n - 4'd1;
            end
            S_ROUND: begin
                r_k <= (round_q > 19'd65535) ? 16'hFFFF : round_q[15:0];
            end
            S_DM1: begin
                // The upper part carries the sign of the term.
                r_lo <= i_pt_data[19:0] * r_k;
                r_hi <= $signed(i_pt_data[39:20]) * $signed({1'b0, r_k});
            end
            S_DM2: begin
                r_dval <= VAL_W'(dsum >>> 16);
            end
            S_DOUT: begin
                if (out_free) begin
                    r_i <= r_i + LEN_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // Output register: holds a result until the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (out_load) begin
            o_valid <= 1'b1;
        end else if (i_ready) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            o_kind  <= load_kind;
            o_elem  <= load_elem;
            o_value <= load_val;
            o_last  <= (load_kind == KIND_KERNEL);
        end
    end

    // The kernel value is a Q0.16 number and alone ends a run.
    a_kernel_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == KIND_KERNEL) |-> (o_last && o_value < 48'd65536))
        else $error("kernel value out of range or not marked last");

    // Derivative terms never close the run.
    a_deriv_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == KIND_DERIV) |-> !o_last)
        else $error("derivative term marked last");

    // The reciprocal estimate is never more than two below the true quotient.
    a_div_corr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CORR1) |-> (r_rem < 32'(m) * 32'd3))
        else $error("series quotient correction out of range");

endmodule

FILE: rtl/diag_gauss_kernel_eval_top.sv
// Top level of the diagonal-weighted Gaussian kernel evaluator.
// Depends on dgk_pkg, dgk_ram, dgk_queue, dgk_front and dgk_back.
//
// Usage:
//   The slave stream carries weight writes (tuser 0) and coordinate pairs (tuser 1).
//   Pairs of one vector may arrive one per cycle while fewer than two vectors are
//   pending; after a vector's last pair the input stalls until the sum is queued.
//   One finished vector may wait in the queue while another is evaluated.
//   The master stream carries, per vector, the derivative terms (tuser 0) in
//   derivative mode and then the kernel value (tuser 1, tlast 1).
//   The shared multiply and divide sequence evaluates the kernel: for each of the
//   first 19 series terms a multiply and a divide by reciprocal with correction,
//   then the last term, one scaling by e^-1 per whole unit of the sum (up to 11)
//   and a rounding step. A sum of 12.0 or more skips the sequence.
//   Each derivative term then takes a RAM read, a multiply and a rounding stage.
//   The output register holds a result while tready is low; the back stalls
//   behind it and the front keeps accepting until two vectors are pending.
//   Reset is synchronous and active low: it sets vector_length to 16,
//   derivative_mode to 0 and empties the pipeline and queue; weights must be
//   written before they are used.
module diag_gauss_kernel_eval_top #(
    parameter int MAX_DIM = dgk_pkg::MAX_DIM_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port.
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [4:0]  i_cfg_data,
    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: weight_index[3:0], weight_value[19:4], first_sample[35:20],
    //        second_sample[51:36], zero fill[55:52]
    input  logic [55:0] s_axis_tdata,
    // tuser: func[0]
    input  logic        s_axis_tuser,
    // Output stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: element_number[3:0], result_value[51:4], zero fill[55:52]
    output logic [55:0] m_axis_tdata,
    // tuser: result_kind[0]
    output logic        m_axis_tuser,
    output logic        m_axis_tlast
);
    import dgk_pkg::*;

    localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

    logic [4:0]        r_vec_len;
    logic              r_deriv;
    logic [LEN_W-1:0]  len_eff;
    logic              push, pop, busy, bank_free;
    t_job              job_in, job_out;
    t_q_status         q_status;
    logic              pt_we, pt_re;
    logic [IW:0]       pt_waddr, pt_raddr;
    logic signed [TERM_W-1:0] pt_wdata, pt_rdata;
    logic [3:0]        out_elem;
    logic [VAL_W-1:0]  out_value;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vec_len <= 5'd16;
            r_deriv   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_VECTOR_LENGTH:   r_vec_len <= i_cfg_data;
                CFG_DERIVATIVE_MODE: r_deriv   <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Length in force: zero acts as one, larger than the table acts as its size.
    always_comb begin
        if (r_vec_len == 5'd0) begin
            len_eff = LEN_W'(1);
        end else if (LEN_W'(r_vec_len) > LEN_W'(MAX_DIM)) begin
            len_eff = LEN_W'(MAX_DIM);
        end else begin
            len_eff = LEN_W'(r_vec_len);
        end
    end

    // A bank of derivative terms is free while fewer than two vectors are pending.
    assign bank_free = (3'(q_status.count) + 3'(busy)) < 3'd2;

    dgk_front #(.MAX_DIM (MAX_DIM)) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (s_axis_tvalid),
        .o_ready         (s_axis_tready),
        .i_func          (s_axis_tuser),
        .i_weight_index  (s_axis_tdata[3:0]),
        .i_weight_value  (s_axis_tdata[19:4]),
        .i_first_sample  (s_axis_tdata[35:20]),
        .i_second_sample (s_axis_tdata[51:36]),
        .i_len           (len_eff),
        .i_deriv         (r_deriv),
        .i_bank_free     (bank_free),
        .o_push          (push),
        .o_job           (job_in),
        .o_pt_we         (pt_we),
        .o_pt_addr       (pt_waddr),
        .o_pt_data       (pt_wdata)
    );

    dgk_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (job_in),
        .i_pop    (pop),
        .o_job    (job_out),
        .o_status (q_status)
    );

    // Derivative terms, two banks so that one vector fills while another drains.
    dgk_ram #(
        .WIDTH (TERM_W),
        .DEPTH (2 ** (IW + 1))
    ) u_terms (
        .i_clk   (i_clk),
        .i_we    (pt_we),
        .i_waddr (pt_waddr),
        .i_wdata (pt_wdata),
        .i_re    (pt_re),
        .i_raddr (pt_raddr),
        .o_rdata (pt_rdata)
    );

    dgk_back #(.MAX_DIM (MAX_DIM)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_status.empty),
        .i_job     (job_out),
        .o_pop     (pop),
        .o_busy    (busy),
        .o_pt_re   (pt_re),
        .o_pt_addr (pt_raddr),
        .i_pt_data (pt_rdata),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_kind    (m_axis_tuser),
        .o_elem    (out_elem),
        .o_value   (out_value),
        .o_last    (m_axis_tlast)
    );

    assign m_axis_tdata = {4'd0, out_value, out_elem};

endmodule
